>>> rtl/tmr_pkg.sv
package tmr_pkg;

  localparam int TIME_BITS = 32;
  localparam int ACTION_W  = 3;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 3'd0,
    ACT_START     = 3'd1,
    ACT_PAUSE     = 3'd2,
    ACT_RESUME    = 3'd3,
    ACT_RESTART   = 3'd4,
    ACT_RESET     = 3'd5,
    ACT_ROLLBACK  = 3'd6,
    ACT_INTERRUPT = 3'd7
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DURATION             = 3'd0,
    REG_TICK_INTERVAL        = 3'd1,
    REG_ROLLBACK_STEP        = 3'd2,
    REG_RESET_ON_START       = 3'd3,
    REG_ROLLBACK_ON_RESET    = 3'd4,
    REG_RESET_AFTER_ROLLBACK = 3'd5
  } reg_idx_t;

  localparam logic [TIME_BITS-1:0] DURATION_RST      = '0;
  localparam logic [TIME_BITS-1:0] TICK_INTERVAL_RST = TIME_BITS'(1000);
  localparam logic [TIME_BITS-1:0] ROLLBACK_STEP_RST = TIME_BITS'(1000);

  typedef struct packed {
    logic [TIME_BITS-1:0] duration;
    logic [TIME_BITS-1:0] tick_interval;
    logic [TIME_BITS-1:0] rollback_step;
    logic                 reset_on_start;
    logic                 rollback_on_reset;
    logic                 reset_after_rollback;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                reset_progress;
    logic                task_running;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] elapsed;
    logic                 ticked;
    logic                 completed;
    logic                 progress_reset;
    logic                 running;
    logic                 rolling_back;
    logic                 task_running;
  } mid_t;

endpackage

>>> rtl/tmr_if.sv
interface tmr_in_if import tmr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                reset_progress;
  logic                task_running;

  modport source (output valid, output action, output reset_progress,
                  output task_running, input ready);
  modport sink   (input valid, input action, input reset_progress,
                  input task_running, output ready);
endinterface

interface tmr_out_if import tmr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] remaining;
  logic                 ticked;
  logic                 completed;
  logic                 progress_reset;
  logic                 running;
  logic                 rolling_back;
  logic                 countdown_paused;
  logic                 rollback_paused;

  modport source (output valid, output elapsed, output remaining, output ticked,
                  output completed, output progress_reset, output running,
                  output rolling_back, output countdown_paused,
                  output rollback_paused, input ready);
  modport sink   (input valid, input elapsed, input remaining, input ticked,
                  input completed, input progress_reset, input running,
                  input rolling_back, input countdown_paused,
                  input rollback_paused, output ready);
endinterface

>>> rtl/tmr_cfg.sv
module tmr_cfg import tmr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duration             <= DURATION_RST;
      cfg_r.tick_interval        <= TICK_INTERVAL_RST;
      cfg_r.rollback_step        <= ROLLBACK_STEP_RST;
      cfg_r.reset_on_start       <= 1'b0;
      cfg_r.rollback_on_reset    <= 1'b0;
      cfg_r.reset_after_rollback <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_DURATION:             cfg_r.duration             <= cfg_pwdata[TIME_BITS-1:0];
        REG_TICK_INTERVAL:        cfg_r.tick_interval        <= cfg_pwdata[TIME_BITS-1:0];
        REG_ROLLBACK_STEP:        cfg_r.rollback_step        <= cfg_pwdata[TIME_BITS-1:0];
        REG_RESET_ON_START:       cfg_r.reset_on_start       <= cfg_pwdata[0];
        REG_ROLLBACK_ON_RESET:    cfg_r.rollback_on_reset    <= cfg_pwdata[0];
        REG_RESET_AFTER_ROLLBACK: cfg_r.reset_after_rollback <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_DURATION:             cfg_prdata = CFG_DW'(cfg_r.duration);
      REG_TICK_INTERVAL:        cfg_prdata = CFG_DW'(cfg_r.tick_interval);
      REG_ROLLBACK_STEP:        cfg_prdata = CFG_DW'(cfg_r.rollback_step);
      REG_RESET_ON_START:       cfg_prdata = CFG_DW'(cfg_r.reset_on_start);
      REG_ROLLBACK_ON_RESET:    cfg_prdata = CFG_DW'(cfg_r.rollback_on_reset);
      REG_RESET_AFTER_ROLLBACK: cfg_prdata = CFG_DW'(cfg_r.reset_after_rollback);
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/tmr_core.sv
module tmr_core import tmr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  tmr_in_if.sink in_ch,
  output logic  mid_valid,
  output mid_t  mid,
  input  logic  mid_ready
);

  logic                 in_v_r;
  in_item_t             in_r;
  logic                 in_ready;
  logic                 fire;

  logic [TIME_BITS-1:0] prog_r, prog_nxt;
  logic                 act_r, act_nxt;
  logic                 rb_r, rb_nxt;
  logic                 mid_v_r;
  mid_t                 mid_r, mid_nxt;

  logic [TIME_BITS:0]   fwd_sum;
  logic [TIME_BITS:0]   rb_diff;
  logic                 fwd_done;
  logic                 rb_empty;
  logic                 at_dur;
  logic                 prog_zero;
  logic                 ticked, completed, prog_rst;

  assign in_ready    = !in_v_r || mid_ready;
  assign in_ch.ready = in_ready;
  assign fire        = in_v_r && mid_ready;
  assign mid_valid   = mid_v_r;
  assign mid         = mid_r;

  // Sum and difference carry one extra bit so the clamps see overflow and borrow
  assign fwd_sum   = {1'b0, prog_r} + {1'b0, cfg.tick_interval};
  assign rb_diff   = {1'b0, prog_r} - {1'b0, cfg.rollback_step};
  assign fwd_done  = fwd_sum >= {1'b0, cfg.duration};
  assign rb_empty  = rb_diff[TIME_BITS] || (rb_diff[TIME_BITS-1:0] == '0);
  assign at_dur    = prog_r >= cfg.duration;
  assign prog_zero = prog_r == '0;

  always_comb begin
    prog_nxt  = prog_r;
    act_nxt   = act_r;
    rb_nxt    = rb_r;
    ticked    = 1'b0;
    completed = 1'b0;
    prog_rst  = 1'b0;
    if (in_r.task_running) begin
      case (action_t'(in_r.action))
        ACT_TICK: begin
          if (act_r) begin
            ticked = 1'b1;
            if (rb_r) begin
              if (rb_empty) begin
                prog_nxt = '0;
                act_nxt  = 1'b0;
                rb_nxt   = 1'b0;
                prog_rst = cfg.reset_after_rollback;
              end else begin
                prog_nxt = rb_diff[TIME_BITS-1:0];
              end
            end else if (fwd_done) begin
              prog_nxt  = cfg.duration;
              act_nxt   = 1'b0;
              completed = 1'b1;
            end else begin
              prog_nxt = fwd_sum[TIME_BITS-1:0];
            end
          end
        end
        ACT_START: begin
          if (!act_r || rb_r) begin
            rb_nxt   = 1'b0;
            prog_rst = prog_zero && cfg.reset_on_start;
            if (at_dur) begin
              prog_nxt  = cfg.duration;
              act_nxt   = 1'b0;
              completed = 1'b1;
            end else begin
              act_nxt = 1'b1;
            end
          end
        end
        ACT_PAUSE: begin
          act_nxt = 1'b0;
        end
        ACT_RESUME: begin
          if (!act_r) begin
            if (rb_r) begin
              if (prog_zero) begin
                act_nxt  = 1'b0;
                rb_nxt   = 1'b0;
                prog_rst = cfg.reset_after_rollback;
              end else begin
                act_nxt = 1'b1;
              end
            end else if (!at_dur) begin
              act_nxt = 1'b1;
            end
          end
        end
        ACT_RESTART: begin
          rb_nxt   = 1'b0;
          prog_nxt = '0;
          prog_rst = in_r.reset_progress;
          if (cfg.duration == '0) begin
            act_nxt   = 1'b0;
            completed = 1'b1;
          end else begin
            act_nxt = 1'b1;
          end
        end
        ACT_RESET: begin
          if (cfg.rollback_on_reset && !prog_zero) begin
            act_nxt = 1'b1;
            rb_nxt  = 1'b1;
          end else begin
            prog_nxt = '0;
            act_nxt  = 1'b0;
            rb_nxt   = 1'b0;
            prog_rst = in_r.reset_progress;
          end
        end
        ACT_ROLLBACK: begin
          if (!prog_zero) begin
            act_nxt = 1'b1;
            rb_nxt  = 1'b1;
          end
        end
        ACT_INTERRUPT: begin
          act_nxt = 1'b0;
          rb_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mid_nxt.elapsed        = prog_nxt;
    mid_nxt.ticked         = ticked;
    mid_nxt.completed      = completed;
    mid_nxt.progress_reset = prog_rst;
    mid_nxt.running        = act_nxt;
    mid_nxt.rolling_back   = rb_nxt;
    mid_nxt.task_running   = in_r.task_running;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      prog_r  <= '0;
      act_r   <= 1'b0;
      rb_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_ch.valid;
      end
      if (mid_ready) begin
        mid_v_r <= in_v_r;
      end
      if (fire) begin
        prog_r <= prog_nxt;
        act_r  <= act_nxt;
        rb_r   <= rb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_r.action         <= in_ch.action;
      in_r.reset_progress <= in_ch.reset_progress;
      in_r.task_running   <= in_ch.task_running;
    end
    if (fire) begin
      mid_r <= mid_nxt;
    end
  end

  a_complete_at_duration: assert property (@(posedge clk) disable iff (!rst_n)
    mid_v_r && mid_r.completed |-> mid_r.elapsed == cfg.duration && !mid_r.running)
    else $error("completion without progress at duration");

  a_events_need_task: assert property (@(posedge clk) disable iff (!rst_n)
    mid_v_r && (mid_r.ticked || mid_r.completed || mid_r.progress_reset)
      |-> mid_r.task_running)
    else $error("event flagged while task not running");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    mid_v_r && mid_r.progress_reset |-> mid_r.elapsed == '0 && !mid_r.rolling_back)
    else $error("progress reset flagged with progress left");

  a_idle_task_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_r.task_running |=> $stable(prog_r) && $stable(act_r) && $stable(rb_r))
    else $error("state changed on a command while task not running");

endmodule

>>> rtl/tmr_fmt.sv
module tmr_fmt import tmr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  mid_valid,
  input  mid_t  mid,
  output logic  mid_ready,
  tmr_out_if.source out_ch
);

  logic                 out_v_r;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [TIME_BITS-1:0] remaining_r;
  logic                 ticked_r, completed_r, prog_rst_r;
  logic                 running_r, rolling_r, cd_paused_r, rb_paused_r;
  logic [TIME_BITS:0]   rem_diff;
  logic                 load;

  assign mid_ready = !out_v_r || out_ch.ready;
  assign load      = mid_valid && mid_ready;
  // Floor at zero on borrow
  assign rem_diff  = {1'b0, cfg.duration} - {1'b0, mid.elapsed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (mid_ready) begin
      out_v_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      elapsed_r   <= mid.elapsed;
      remaining_r <= rem_diff[TIME_BITS] ? '0 : rem_diff[TIME_BITS-1:0];
      ticked_r    <= mid.ticked;
      completed_r <= mid.completed;
      prog_rst_r  <= mid.progress_reset;
      running_r   <= mid.running;
      rolling_r   <= mid.rolling_back;
      cd_paused_r <= mid.task_running && !mid.running && !mid.rolling_back &&
                     (mid.elapsed != '0) && !rem_diff[TIME_BITS] &&
                     (rem_diff[TIME_BITS-1:0] != '0);
      rb_paused_r <= mid.task_running && mid.rolling_back && !mid.running &&
                     (mid.elapsed != '0);
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.elapsed          = elapsed_r;
  assign out_ch.remaining        = remaining_r;
  assign out_ch.ticked           = ticked_r;
  assign out_ch.completed        = completed_r;
  assign out_ch.progress_reset   = prog_rst_r;
  assign out_ch.running          = running_r;
  assign out_ch.rolling_back     = rolling_r;
  assign out_ch.countdown_paused = cd_paused_r;
  assign out_ch.rollback_paused  = rb_paused_r;

endmodule

>>> rtl/countdown_timer_with_rollback_top.sv
// Count-up timer with forward and rollback modes, driven by one command per
// transaction on in_ch (tick, start, pause, resume, restart, reset, rollback,
// interrupt). Each accepted command yields exactly one result transaction on
// out_ch with progress, remaining time, event flags and pause status.
// Registers are written over the APB-style cfg_ port (word address per
// register, pready always high); write them only while no command is in flight.
// Throughput: one command per cycle while out_ch.ready is high. The limit is
// the state update loop on progress (one 33-bit add or subtract with clamp
// and compare). A command is accepted into the input register, then passes
// the state update register and the result register before it reaches out_ch.
// Reset: rst_n low at a clock edge clears progress and mode flags, empties
// the pipeline and loads register defaults (duration 0, interval 1000,
// rollback step 1000, option bits 0).
// Stall: while a held result waits on out_ch.ready, the result register and
// the state update register hold; the input register takes one more command
// if empty, then in_ch.ready stays low until the held result transaction is taken.
module countdown_timer_with_rollback_top import tmr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tmr_in_if.sink            in_ch,
  tmr_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;
  logic mid_valid;
  logic mid_ready;
  mid_t mid;

  tmr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tmr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready)
  );

  tmr_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready),
    .out_ch    (out_ch)
  );

endmodule
